>>> design/ptree_pkg.sv
// Shared constants and types for the palindromic tree builder.
package ptree_pkg;

  localparam int MAX_LEN  = 4096;
  localparam int ALPHABET = 26;
  localparam int NODE_CAP = MAX_LEN + 2;

  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int NODE_W  = $clog2(NODE_CAP);
  localparam int LEN_W   = POS_W;
  localparam int CH_W    = 5;
  localparam int MASK_W  = ALPHABET;
  localparam int CHILD_DEPTH = NODE_CAP * (2 ** CH_W);

  typedef logic [CH_W-1:0]   chr_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [MASK_W-1:0] mask_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    node_t            link;
    mask_t            letters;
    node_t            parent;
    chr_t             chr;
  } node_rec_t;

endpackage

>>> design/ptree_in_if.sv
// Input channel: one letter per transaction.
interface ptree_in_if;
  logic                 valid;
  logic                 ready;
  ptree_pkg::chr_t      letter;
  logic                 start_req;
  modport source (output valid, output letter, output start_req, input ready);
  modport sink (input valid, input letter, input start_req, output ready);
endinterface

>>> design/ptree_out_if.sv
// Output channel: longest palindromic suffix report per transaction.
interface ptree_out_if;
  logic                                valid;
  logic                                ready;
  logic [ptree_pkg::LEN_W-1:0]         pal_len;
  ptree_pkg::node_t                    node_index;
  logic                                created;
  ptree_pkg::mask_t                    letters_mask;
  logic                                overflow;
  modport source (output valid, output pal_len, output node_index, output created,
                  output letters_mask, output overflow, input ready);
  modport sink (input valid, input pal_len, input node_index, input created,
                input letters_mask, input overflow, output ready);
endinterface

>>> design/ptree_ram.sv
// Generic simple dual-port RAM with registered read.
module ptree_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/palindromic_tree_insert.sv
// Palindromic tree builder: sequencer walking suffix links over node, text and edge RAMs.
// Each suffix-link step reads the node, then compares the letter before its palindrome,
// skipping the compare when that index falls before the text or at the minus-one root.
// A known edge is read and checked; a new node follows a second walk and a link read,
// unless its parent is the minus-one root. A letter past capacity is ignored (overflow).
// New letters are taken only in idle. Reset clears control and counters, not the RAMs.
module palindromic_tree_insert (
  input logic        clk,
  input logic        rst,
  ptree_in_if.sink   data_in,
  ptree_out_if.source data_out
);
  typedef enum logic [3:0] {
    S_IDLE, S_WNODE, S_WTXT, S_WCMP, S_CHREAD, S_CHVAL, S_LINK, S_CREATE, S_FIN
  } state_t;

  localparam int TXT_AW = $clog2(ptree_pkg::MAX_LEN + 1);
  localparam int CH_AW  = $clog2(ptree_pkg::CHILD_DEPTH);
  localparam int IDX_W  = ptree_pkg::POS_W + 2;

  state_t state;
  ptree_pkg::pos_t  pos;
  ptree_pkg::node_t last, total, v, u, w, link;
  ptree_pkg::chr_t  c;
  logic             walk2;
  logic signed [ptree_pkg::LEN_W:0] cur_len;
  ptree_pkg::node_t cur_link;
  ptree_pkg::mask_t cur_let;
  logic [ptree_pkg::LEN_W-1:0] new_len;
  ptree_pkg::mask_t new_let;
  logic [ptree_pkg::LEN_W-1:0] r_len;
  ptree_pkg::node_t r_node;
  logic r_created, r_ovf;
  ptree_pkg::mask_t r_let;

  logic out_valid;

  ptree_pkg::node_rec_t node_q, node_wdata;
  ptree_pkg::node_t     node_raddr;
  logic                 node_we;
  ptree_pkg::chr_t      text_q;
  logic                 text_we;
  logic [TXT_AW-1:0]    text_waddr, text_raddr;
  ptree_pkg::node_t     child_q;
  logic                 child_we;
  logic [CH_AW-1:0]     child_waddr, child_raddr;

  ptree_pkg::chr_t  c_in;
  logic signed [ptree_pkg::LEN_W:0] len_comb;
  ptree_pkg::node_t link_comb;
  ptree_pkg::mask_t let_comb;
  logic signed [IDX_W-1:0] idx;
  ptree_pkg::node_t fresh;
  logic room;
  ptree_pkg::pos_t pos_eff;
  ptree_pkg::node_t last_eff, total_eff;

  assign c_in = (data_in.letter >= ptree_pkg::CH_W'(ptree_pkg::ALPHABET)) ?
                ptree_pkg::CH_W'(ptree_pkg::ALPHABET - 1) : data_in.letter;
  assign pos_eff   = data_in.start_req ? '0 : pos;
  assign last_eff  = data_in.start_req ? '0 : last;
  assign total_eff = data_in.start_req ? ptree_pkg::NODE_W'(1) : total;

  always_comb begin
    if (v == '0) begin
      len_comb  = '0;
      link_comb = ptree_pkg::NODE_W'(1);
      let_comb  = '0;
    end else begin
      len_comb  = $signed({1'b0, node_q.len});
      link_comb = node_q.link;
      let_comb  = node_q.letters;
    end
  end

  assign idx = $signed({2'b00, pos}) - IDX_W'(len_comb) - IDX_W'(1);
  assign fresh = total + ptree_pkg::NODE_W'(1);
  assign room  = ({1'b0, total} + (ptree_pkg::NODE_W + 1)'(1)) <
                 (ptree_pkg::NODE_W + 1)'(ptree_pkg::NODE_CAP);

  assign data_in.ready = (state == S_IDLE);
  assign node_raddr    = (state == S_CHREAD) ? child_q : v;
  assign text_raddr    = idx[TXT_AW-1:0];
  assign child_raddr   = {v, c};
  assign text_we       = (state == S_IDLE) && data_in.valid &&
                         (pos_eff < ptree_pkg::POS_W'(ptree_pkg::MAX_LEN));
  assign text_waddr    = pos_eff + ptree_pkg::POS_W'(1);
  assign node_we       = (state == S_CREATE);
  assign node_wdata    = '{len: new_len, link: link, letters: new_let, parent: u, chr: c};
  assign child_we      = (state == S_CREATE);
  assign child_waddr   = {u, c};

  ptree_ram #(.WIDTH(ptree_pkg::CH_W), .DEPTH(ptree_pkg::MAX_LEN + 1)) u_text (
    .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(c_in),
    .raddr(text_raddr), .rdata(text_q));

  ptree_ram #(.WIDTH($bits(ptree_pkg::node_rec_t)), .DEPTH(ptree_pkg::NODE_CAP)) u_node (
    .clk(clk), .we(node_we), .waddr(fresh), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_q));

  ptree_ram #(.WIDTH(ptree_pkg::NODE_W), .DEPTH(ptree_pkg::CHILD_DEPTH)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(fresh),
    .raddr(child_raddr), .rdata(child_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      last      <= '0;
      total     <= ptree_pkg::NODE_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || data_out.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && data_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (data_in.valid) begin
            last  <= last_eff;
            total <= total_eff;
            c     <= c_in;
            walk2 <= 1'b0;
            v     <= last_eff;
            if (pos_eff >= ptree_pkg::POS_W'(ptree_pkg::MAX_LEN)) begin
              pos       <= pos_eff;
              r_len     <= '0;
              r_node    <= '0;
              r_created <= 1'b0;
              r_let     <= '0;
              r_ovf     <= 1'b1;
              state     <= S_FIN;
            end else begin
              pos   <= pos_eff + ptree_pkg::POS_W'(1);
              state <= S_WNODE;
            end
          end
        end
        S_WNODE: begin
          if (v == ptree_pkg::NODE_W'(1)) begin
            if (!walk2) begin
              cur_len <= -1;
              cur_let <= '0;
              u       <= v;
            end
            state   <= walk2 ? S_LINK : S_CHREAD;
          end else begin
            state <= S_WTXT;
          end
        end
        S_WTXT: begin
          if (!walk2) begin
            cur_len <= len_comb;
            cur_let <= let_comb;
            u       <= v;
          end
          cur_link <= link_comb;
          if (idx <= 0) begin
            v     <= link_comb;
            state <= S_WNODE;
          end else begin
            state <= S_WCMP;
          end
        end
        S_WCMP: begin
          if (text_q == c) begin
            state <= walk2 ? S_LINK : S_CHREAD;
          end else begin
            v     <= cur_link;
            state <= S_WNODE;
          end
        end
        S_CHREAD, S_CHVAL: begin
          if (state == S_CHREAD && child_q >= ptree_pkg::NODE_W'(2) && child_q <= total) begin
            w     <= child_q;
            state <= S_CHVAL;
          end else if (state == S_CHVAL && node_q.parent == u && node_q.chr == c) begin
            r_len     <= node_q.len;
            r_node    <= w;
            r_created <= 1'b0;
            r_let     <= node_q.letters;
            r_ovf     <= 1'b0;
            last      <= w;
            state     <= S_FIN;
          end else if (room) begin
            new_len <= ptree_pkg::LEN_W'(cur_len + 2);
            new_let <= cur_let | (ptree_pkg::MASK_W'(1) << c);
            if (u == ptree_pkg::NODE_W'(1)) begin
              link  <= '0;
              state <= S_CREATE;
            end else begin
              v     <= cur_link;
              walk2 <= 1'b1;
              state <= S_WNODE;
            end
          end else begin
            r_len     <= '0;
            r_node    <= '0;
            r_created <= 1'b0;
            r_let     <= '0;
            r_ovf     <= 1'b0;
            last      <= '0;
            state     <= S_FIN;
          end
        end
        S_LINK: begin
          link  <= child_q;
          state <= S_CREATE;
        end
        S_CREATE: begin
          total     <= fresh;
          last      <= fresh;
          r_len     <= new_len;
          r_node    <= fresh;
          r_created <= 1'b1;
          r_let     <= new_let;
          r_ovf     <= 1'b0;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || data_out.ready) begin
            data_out.pal_len      <= r_len;
            data_out.node_index   <= r_node;
            data_out.created      <= r_created;
            data_out.letters_mask <= r_let;
            data_out.overflow     <= r_ovf;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign data_out.valid = out_valid;

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    state == S_CREATE |=> total == $past(total) + ptree_pkg::NODE_W'(1))
    else $error("node count did not advance on creation");

  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
    pos <= ptree_pkg::POS_W'(ptree_pkg::MAX_LEN))
    else $error("text position beyond capacity");

  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> {1'b0, total} <= {1'b0, pos} + (ptree_pkg::POS_W + 1)'(1))
    else $error("more nodes than letters allow");

endmodule

>>> tb/sv/ptree_tb_if.sv
// Testbench item and report types for the palindromic tree builder.
package ptree_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [12:0] pal_len;
    logic [12:0] node_index;
    logic        created;
    logic [25:0] letters_mask;
    logic        overflow;
  } suffix_report_t;

  typedef struct {
    logic [4:0] letter;
    logic       start_req;
  } letter_item_t;
endpackage

>>> tb/sv/palindromic_tree_insert_tb.sv
// Self-checking testbench for the palindromic tree builder with a built-in eertree predictor.
module palindromic_tree_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptree_in_if  data_in ();
  ptree_out_if data_out ();

  palindromic_tree_insert dut (
    .clk(clk),
    .rst(rst),
    .data_in(data_in),
    .data_out(data_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int          txt [0:ptree_pkg::MAX_LEN];
  int          plen [0:ptree_pkg::NODE_CAP-1];
  int          slink [0:ptree_pkg::NODE_CAP-1];
  logic [25:0] pmask [0:ptree_pkg::NODE_CAP-1];
  int          edges [int];
  int          tail_node;
  int          text_pos;
  int          node_count;

  ptree_tb_pkg::letter_item_t   pending_letters[$];
  ptree_tb_pkg::suffix_report_t expected_reports[$];
  int             errors = 0;
  int             report_count = 0;
  int             created_count = 0;
  int             overflow_count = 0;
  int             cycles = 0;
  bit             calm = 1'b0;
  bit             hold_req = 1'b0;
  int             src_gap = 0;
  int             snk_gap = 0;
  int             hold_left = 0;

  function automatic void tree_clear();
    edges.delete();
    txt[0] = 31;
    plen[0] = 0;
    plen[1] = -1;
    slink[0] = 1;
    slink[1] = 0;
    pmask[0] = '0;
    pmask[1] = '0;
    tail_node = 0;
    text_pos = 0;
    node_count = 1;
  endfunction

  function automatic int edge_of(int v, int c);
    return edges.exists(v * 32 + c) ? edges[v * 32 + c] : 0;
  endfunction

  function automatic bit grows(int v, int p);
    int idx;
    idx = p - plen[v] - 1;
    if (idx < 0 || idx > p) return 1'b0;
    return txt[idx] == txt[p];
  endfunction

  function automatic int climb(int v, int p);
    int guard;
    guard = 0;
    while (v != 1 && !grows(v, p) && guard <= ptree_pkg::NODE_CAP) begin
      v = slink[v];
      if (v >= ptree_pkg::NODE_CAP) v = 1;
      guard++;
    end
    return v;
  endfunction

  function automatic ptree_tb_pkg::suffix_report_t insert_letter(
      ptree_tb_pkg::letter_item_t it);
    ptree_tb_pkg::suffix_report_t r;
    int c, u, fresh, nd;
    r = '{default: '0};
    c = it.letter;
    if (it.start_req) tree_clear();
    if (c >= ptree_pkg::ALPHABET) c = ptree_pkg::ALPHABET - 1;
    if (text_pos >= ptree_pkg::MAX_LEN) begin
      r.overflow = 1'b1;
      return r;
    end
    text_pos++;
    txt[text_pos] = c;
    u = climb(tail_node, text_pos);
    if (edge_of(u, c) == 0 && node_count + 1 < ptree_pkg::NODE_CAP) begin
      node_count++;
      fresh = node_count;
      plen[fresh] = plen[u] + 2;
      slink[fresh] = (u == 1) ? 0 : edge_of(climb(slink[u], text_pos), c);
      edges[u * 32 + c] = fresh;
      pmask[fresh] = pmask[u] | (26'd1 << c);
      r.created = 1'b1;
    end
    nd = edge_of(u, c);
    tail_node = nd;
    r.pal_len = plen[nd][12:0];
    r.node_index = nd[12:0];
    r.letters_mask = pmask[nd];
    return r;
  endfunction

  function automatic void add_letter(int c, bit s);
    ptree_tb_pkg::letter_item_t it;
    it.letter = c[4:0];
    it.start_req = s;
    pending_letters.push_back(it);
    expected_reports.push_back(insert_letter(it));
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      data_in.valid <= 1'b0;
      data_in.letter <= '0;
      data_in.start_req <= 1'b0;
    end else begin
      if (data_in.valid && data_in.ready) void'(pending_letters.pop_front());
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        if (!(data_in.valid && !data_in.ready)) data_in.valid <= 1'b0;
      end else if (!(data_in.valid && !data_in.ready)) begin
        if (!calm && $urandom_range(0, 15) == 0) begin
          src_gap <= $urandom_range(1, 16);
          data_in.valid <= 1'b0;
        end else if (pending_letters.size() > 0) begin
          data_in.valid <= 1'b1;
          data_in.letter <= pending_letters[0].letter;
          data_in.start_req <= pending_letters[0].start_req;
        end else begin
          data_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      data_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      data_out.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      data_out.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      data_out.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      snk_gap <= $urandom_range(1, 16);
      data_out.ready <= 1'b0;
    end else begin
      data_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ptree_tb_pkg::suffix_report_t e;
    if (!rst && data_out.valid && data_out.ready) begin
      report_count <= report_count + 1;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected transaction, actual len=%0d node=%0d", $realtime,
                 data_out.pal_len, data_out.node_index);
        errors <= errors + 1;
      end else begin
        e = expected_reports.pop_front();
        if (e.overflow) overflow_count <= overflow_count + 1;
        if (e.created) created_count <= created_count + 1;
        if (data_out.pal_len !== e.pal_len || data_out.node_index !== e.node_index ||
            data_out.created !== e.created || data_out.letters_mask !== e.letters_mask ||
            data_out.overflow !== e.overflow) begin
          $display("%0t: mismatch expected len=%0d node=%0d new=%0b mask=%h ovf=%0b",
                   $realtime, e.pal_len, e.node_index, e.created, e.letters_mask,
                   e.overflow);
          $display("%0t:          actual   len=%0d node=%0d new=%0b mask=%h ovf=%0b",
                   $realtime, data_out.pal_len, data_out.node_index, data_out.created,
                   data_out.letters_mask, data_out.overflow);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("palindromic_tree_insert verification failed");
      $finish;
    end
  end

  initial begin
    int n, k, c, half;
    int word[$];
    tree_clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_letter(0, 1'b1);
    add_letter(0, 1'b0);
    add_letter(25, 1'b0);
    add_letter(0, 1'b0);
    add_letter(0, 1'b0);
    add_letter(30, 1'b0);
    add_letter(31, 1'b0);
    add_letter(26, 1'b0);
    add_letter(1, 1'b0);
    add_letter(2, 1'b1);
    add_letter(2, 1'b0);
    add_letter(2, 1'b0);
    add_letter(13, 1'b0);
    add_letter(2, 1'b0);
    add_letter(5, 1'b1);

    hold_req = 1'b1;
    for (n = 0; n < 40; n++) add_letter($urandom_range(0, 2), 1'b0);

    while (expected_reports.size() + pending_letters.size() > 60) @(posedge clk);
    for (n = 0; n < 170; n++) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        add_letter($urandom_range(0, 31), $urandom_range(0, 7) == 0);
      end else if (k < 5) begin
        add_letter($urandom_range(0, 2), 1'b0);
      end else begin
        word.delete();
        half = $urandom_range(1, 6);
        for (c = 0; c < half; c++) word.push_back($urandom_range(0, k < 8 ? 3 : 25));
        for (c = 0; c < half; c++) add_letter(word[c], 1'b0);
        if ($urandom_range(0, 1)) add_letter($urandom_range(0, 25), 1'b0);
        for (c = half - 1; c >= 0; c--) add_letter(word[c], 1'b0);
      end
      while (pending_letters.size() > 40) @(posedge clk);
    end

    calm = 1'b1;
    add_letter(7, 1'b1);
    for (n = 0; n < 30; n++) add_letter($urandom_range(0, 3), 1'b0);

    while (pending_letters.size() > 0 || expected_reports.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Checked %0d reports: %0d new nodes, %0d overflows, palindromic runs,",
             report_count, created_count, overflow_count);
    $display("restarts, out-of-range letters and a long output stall.");
    if (errors == 0) begin
      $display("palindromic_tree_insert verification clean");
    end else begin
      $display("palindromic_tree_insert verification failed");
    end
    $finish;
  end
endmodule
